[hw/rtl/kmc_pkg.sv]
// Shared constants, types and opcodes for the k-means clustering block.
`timescale 1ns / 1ps
package kmc_pkg;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_FEATURES = 8;
  localparam int MAX_CLUSTERS = 16;
  localparam int FEATURE_BITS = 16;

  localparam int POINT_AW  = $clog2(MAX_POINTS);
  localparam int COUNT_W   = POINT_AW + 1;
  localparam int CLUSTER_W = $clog2(MAX_CLUSTERS);
  localparam int DIFF_W    = FEATURE_BITS + 1;
  localparam int SQ_W      = 2 * FEATURE_BITS + 1;
  localparam int DIST_W    = SQ_W + $clog2(MAX_FEATURES);
  localparam int SUM_W     = FEATURE_BITS + POINT_AW;

  typedef logic [MAX_FEATURES-1:0][FEATURE_BITS-1:0] row_t;
  typedef logic [MAX_FEATURES-1:0][SQ_W-1:0] sq_vec_t;
  typedef logic [MAX_FEATURES-1:0][SUM_W-1:0] sum_row_t;

  typedef struct packed {
    logic                 valid;
    logic [CLUSTER_W-1:0] idx;
  } tag_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_ITERS    = 2'd1;
  localparam logic [1:0] REG_FEATURES = 2'd2;
endpackage

[hw/rtl/kmc_lane.sv]
// One feature lane: registered squared difference of point and centroid.
`timescale 1ns / 1ps
module kmc_lane (
  input  logic                                 clk,
  input  logic                                 lane_on,
  input  logic signed [kmc_pkg::FEATURE_BITS-1:0] pt,
  input  logic signed [kmc_pkg::FEATURE_BITS-1:0] ctr,
  output logic [kmc_pkg::SQ_W-1:0]             sq
);
  logic signed [kmc_pkg::DIFF_W-1:0]     diff;
  logic signed [2*kmc_pkg::DIFF_W-1:0]   prod;

  assign diff = kmc_pkg::DIFF_W'(pt) - kmc_pkg::DIFF_W'(ctr);
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq <= lane_on ? prod[kmc_pkg::SQ_W-1:0] : '0;
  end
endmodule

[hw/rtl/kmc_merge.sv]
// Merging stage: sums the lane squares and keeps the nearest centroid.
`timescale 1ns / 1ps
module kmc_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  kmc_pkg::sq_vec_t                sq,
  input  kmc_pkg::tag_t                   tag,
  output logic [kmc_pkg::CLUSTER_W-1:0]   best_idx
);
  logic [kmc_pkg::DIST_W-1:0] cur_d;
  logic [kmc_pkg::DIST_W-1:0] dist_sum;
  logic [kmc_pkg::DIST_W-1:0] min_d;
  kmc_pkg::tag_t              tag_a;

  always_comb begin
    dist_sum = '0;
    for (int j = 0; j < kmc_pkg::MAX_FEATURES; j++) begin
      dist_sum = dist_sum + kmc_pkg::DIST_W'(sq[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else begin
      tag_a <= tag;
    end
    cur_d <= dist_sum;
    // Strict compare keeps the lowest index on ties.
    if (tag_a.valid && (tag_a.idx == '0 || cur_d < min_d)) begin
      min_d    <= cur_d;
      best_idx <= tag_a.idx;
    end
  end
endmodule

[hw/rtl/kmc_div.sv]
// Serial restoring divider for the truncated centroid mean.
`timescale 1ns / 1ps
module kmc_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [kmc_pkg::SUM_W-1:0]       dividend,
  input  logic [kmc_pkg::COUNT_W-1:0]            divisor,
  output logic                                   done,
  output logic [kmc_pkg::FEATURE_BITS-1:0]       quotient
);
  localparam int CNT_W = $clog2(kmc_pkg::SUM_W);

  logic                          running;
  logic [CNT_W-1:0]              cnt;
  logic                          neg;
  logic [kmc_pkg::SUM_W-1:0]     q;
  logic [kmc_pkg::COUNT_W:0]     rem;
  logic [kmc_pkg::COUNT_W-1:0]   dvs;
  logic [kmc_pkg::COUNT_W:0]     trial;
  logic [kmc_pkg::SUM_W-1:0]     q_signed;

  assign trial    = {rem[kmc_pkg::COUNT_W-1:0], q[kmc_pkg::SUM_W-1]};
  assign q_signed = neg ? (~q + 1'b1) : q;
  assign quotient = q_signed[kmc_pkg::FEATURE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CNT_W'(kmc_pkg::SUM_W - 1));
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CNT_W'(kmc_pkg::SUM_W - 1)) begin
        running <= 1'b0;
      end
    end
    if (start) begin
      cnt <= '0;
      neg <= dividend[kmc_pkg::SUM_W-1];
      q   <= dividend[kmc_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        q   <= {q[kmc_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[kmc_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

[hw/rtl/kmeans_clustering.sv]
// Top level of the k-means clustering block.
`timescale 1ns / 1ps
// Lloyd k-means clustering over a stored set of up to 1024 points.
// Input channel: in_valid / in_stall with opcode, point_index and eight
// signed Q8.8 features. An item is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with status,
// assigned_cluster, echo_index and point_count; one result per item.
// A load item writes the point memory and its result is shown the next
// cycle, so loads sustain one item per cycle while out_stall is low. A read
// item goes through the registered assignment memory and the S_READ state.
// A clear item resets the point count. A run item seeds k centroids through
// S_SEED_RD and S_SEED_WR and then runs the rounds: every point is read
// once per round and compared against the k centroids, one centroid per
// cycle across eight parallel feature lanes; the round then visits all
// eight lanes of each centroid, running the serial divide for a used lane
// of a nonempty centroid and setting the other lanes to zero.
// Configuration writes (cfg_valid / cfg_ready) are always ready and are
// meant only while the block is idle. Reset clears the point count and
// loads default register values; no memory is swept. While out_stall holds
// a result, at most that one result waits and no new item is taken.
module kmeans_clustering (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              opcode,
  input  logic [9:0]                              point_index,
  input  logic signed [15:0]                      feature_0,
  input  logic signed [15:0]                      feature_1,
  input  logic signed [15:0]                      feature_2,
  input  logic signed [15:0]                      feature_3,
  input  logic signed [15:0]                      feature_4,
  input  logic signed [15:0]                      feature_5,
  input  logic signed [15:0]                      feature_6,
  input  logic signed [15:0]                      feature_7,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              status,
  output logic [3:0]                              assigned_cluster,
  output logic [9:0]                              echo_index,
  output logic [10:0]                             point_count,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [7:0]                              cfg_data
);
  localparam int CW = kmc_pkg::CLUSTER_W;
  localparam int AW = kmc_pkg::POINT_AW;
  localparam int NW = kmc_pkg::COUNT_W;
  localparam int FB = kmc_pkg::FEATURE_BITS;
  localparam int LW = $clog2(kmc_pkg::MAX_FEATURES);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_READ     = 10'b0000000010,
    S_SEED_RD  = 10'b0000000100,
    S_SEED_WR  = 10'b0000001000,
    S_AS_RD    = 10'b0000010000,
    S_AS_DIST  = 10'b0000100000,
    S_AS_DRAIN = 10'b0001000000,
    S_AS_ACC   = 10'b0010000000,
    S_UP_START = 10'b0100000000,
    S_UP_WAIT  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers and their effective values.
  logic [4:0] cluster_count;
  logic [7:0] iteration_count;
  logic [3:0] feature_count;
  logic [CW:0] k_eff;
  logic [7:0]  iters_eff;
  logic [LW:0] dim_eff;

  assign k_eff = (cluster_count == '0) ? (CW+1)'(1) :
                 (cluster_count > 5'(kmc_pkg::MAX_CLUSTERS)) ? (CW+1)'(kmc_pkg::MAX_CLUSTERS) :
                 cluster_count[CW:0];
  assign iters_eff = (iteration_count == '0) ? 8'd1 : iteration_count;
  assign dim_eff = (feature_count == '0) ? (LW+1)'(1) :
                   (feature_count > 4'(kmc_pkg::MAX_FEATURES)) ?
                   (LW+1)'(kmc_pkg::MAX_FEATURES) : feature_count[LW:0];

  assign cfg_ready = 1'b1;

  // Memories.
  kmc_pkg::row_t point_mem [kmc_pkg::MAX_POINTS];
  logic [CW-1:0] assign_mem [kmc_pkg::MAX_POINTS];
  kmc_pkg::row_t pdata;
  logic [CW-1:0] adata;

  // Centroids, per-cluster sums and member counts.
  kmc_pkg::row_t     cent [kmc_pkg::MAX_CLUSTERS];
  kmc_pkg::sum_row_t sums [kmc_pkg::MAX_CLUSTERS];
  logic [NW-1:0]     counts [kmc_pkg::MAX_CLUSTERS];

  logic [NW-1:0] n;
  logic [AW-1:0] seed_idx;
  logic [AW-1:0] p;
  logic [CW-1:0] cq;
  logic [CW-1:0] uc;
  logic [LW-1:0] uj;
  logic [7:0]    it;
  logic          drain;

  logic [CW-1:0]     best_idx;
  logic [CW-1:0]     sidx;
  kmc_pkg::row_t     cent_row;
  kmc_pkg::sum_row_t sum_row;
  logic [NW-1:0]     cnt_row;
  kmc_pkg::sq_vec_t  sq;
  kmc_pkg::tag_t     tag1;

  logic          in_acc;
  logic          last_c;
  logic          last_uc;
  logic          div_start;
  logic          div_done;
  logic [FB-1:0] div_q;
  logic          lane_used;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign sidx     = (state == S_AS_ACC) ? best_idx : uc;
  assign sum_row  = sums[sidx];
  assign cnt_row  = counts[sidx];
  assign cent_row = cent[cq];

  assign last_c    = ({1'b0, cq} == k_eff - 1'b1);
  assign last_uc   = ({1'b0, uc} == k_eff - 1'b1);
  assign lane_used = ({1'b0, uj} < dim_eff) && (cnt_row != '0);
  assign div_start = (state == S_UP_START) && lane_used;

  // Feature lanes working on one point against one centroid per cycle.
  for (genvar j = 0; j < kmc_pkg::MAX_FEATURES; j++) begin : g_lane
    kmc_lane u_lane (
      .clk     (clk),
      .lane_on ((LW+1)'(j) < dim_eff),
      .pt      (pdata[j]),
      .ctr     (cent_row[j]),
      .sq      (sq[j])
    );
  end

  kmc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .sq       (sq),
    .tag      (tag1),
    .best_idx (best_idx)
  );

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_row[uj]),
    .divisor  (cnt_row),
    .done     (div_done),
    .quotient (div_q)
  );

  // Point memory: written by loads, read for seeding and assignment.
  always_ff @(posedge clk) begin
    if (in_acc && opcode == kmc_pkg::OP_LOAD && n < NW'(kmc_pkg::MAX_POINTS)) begin
      point_mem[n[AW-1:0]] <= {feature_7, feature_6, feature_5, feature_4,
                               feature_3, feature_2, feature_1, feature_0};
    end
    if (state == S_SEED_RD) begin
      pdata <= point_mem[seed_idx];
    end else if (state == S_AS_RD) begin
      pdata <= point_mem[p];
    end
  end

  // Assignment memory.
  always_ff @(posedge clk) begin
    if (state == S_AS_ACC) begin
      assign_mem[p] <= best_idx;
    end
    if (in_acc && opcode == kmc_pkg::OP_READ) begin
      adata <= assign_mem[point_index];
    end
  end

  // Centroids, sums and counts.
  always_ff @(posedge clk) begin
    if (state == S_SEED_WR) begin
      cent[uc] <= pdata;
    end
    if (state == S_UP_START && !lane_used) begin
      cent[uc][uj] <= '0;
    end
    if (state == S_UP_WAIT && div_done) begin
      cent[uc][uj] <= div_q;
    end
    if (state == S_AS_RD && p == '0) begin
      for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++) begin
        sums[c]   <= '0;
        counts[c] <= '0;
      end
    end else if (state == S_AS_ACC) begin
      for (int j = 0; j < kmc_pkg::MAX_FEATURES; j++) begin
        if ((LW+1)'(j) < dim_eff) begin
          sums[best_idx][j] <= sum_row[j] +
                               kmc_pkg::SUM_W'($signed(pdata[j]));
        end
      end
      counts[best_idx] <= cnt_row + 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      n               <= '0;
      tag1            <= '0;
      cluster_count   <= 5'd5;
      iteration_count <= 8'd20;
      feature_count   <= 4'd8;
    end else begin
      tag1 <= '{valid: (state == S_AS_DIST), idx: cq};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kmc_pkg::REG_CLUSTERS: cluster_count   <= cfg_data[4:0];
          kmc_pkg::REG_ITERS:    iteration_count <= cfg_data;
          kmc_pkg::REG_FEATURES: feature_count   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            assigned_cluster <= '0;
            echo_index       <= '0;
            status           <= kmc_pkg::ST_OK;
            case (kmc_pkg::opcode_t'(opcode))
              kmc_pkg::OP_LOAD: begin
                out_valid <= 1'b1;
                if (n >= NW'(kmc_pkg::MAX_POINTS)) begin
                  status      <= kmc_pkg::ST_FULL;
                  point_count <= n;
                end else begin
                  echo_index  <= n[AW-1:0];
                  n           <= n + 1'b1;
                  point_count <= n + 1'b1;
                end
              end
              kmc_pkg::OP_RUN: begin
                point_count <= n;
                if (n == '0) begin
                  status    <= kmc_pkg::ST_EMPTY;
                  out_valid <= 1'b1;
                end else begin
                  seed_idx <= '0;
                  uc       <= '0;
                  state    <= S_SEED_RD;
                end
              end
              kmc_pkg::OP_READ: begin
                echo_index  <= point_index;
                point_count <= n;
                if ({1'b0, point_index} >= n) begin
                  status    <= kmc_pkg::ST_RANGE;
                  out_valid <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                n           <= '0;
                point_count <= '0;
                out_valid   <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          assigned_cluster <= adata;
          out_valid        <= 1'b1;
          state            <= S_IDLE;
        end
        S_SEED_RD: begin
          state <= S_SEED_WR;
        end
        S_SEED_WR: begin
          seed_idx <= ({1'b0, seed_idx} + 1'b1 == n) ? '0 : seed_idx + 1'b1;
          if (last_uc) begin
            it    <= '0;
            p     <= '0;
            state <= S_AS_RD;
          end else begin
            uc    <= uc + 1'b1;
            state <= S_SEED_RD;
          end
        end
        S_AS_RD: begin
          cq    <= '0;
          state <= S_AS_DIST;
        end
        S_AS_DIST: begin
          if (last_c) begin
            drain <= 1'b0;
            state <= S_AS_DRAIN;
          end else begin
            cq <= cq + 1'b1;
          end
        end
        S_AS_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_AS_ACC;
          end
        end
        S_AS_ACC: begin
          if ({1'b0, p} + 1'b1 == n) begin
            uc    <= '0;
            uj    <= '0;
            state <= S_UP_START;
          end else begin
            p     <= p + 1'b1;
            state <= S_AS_RD;
          end
        end
        S_UP_START, S_UP_WAIT: begin
          if (state == S_UP_START && lane_used) begin
            state <= S_UP_WAIT;
          end else if (state == S_UP_START || div_done) begin
            state <= S_UP_START;
            uj    <= uj + 1'b1;
            if (uj == LW'(kmc_pkg::MAX_FEATURES - 1)) begin
              uc <= uc + 1'b1;
              if (last_uc) begin
                if (it + 1'b1 == iters_eff) begin
                  status           <= kmc_pkg::ST_OK;
                  assigned_cluster <= '0;
                  echo_index       <= '0;
                  out_valid        <= 1'b1;
                  state            <= S_IDLE;
                end else begin
                  it    <= it + 1'b1;
                  p     <= '0;
                  state <= S_AS_RD;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(kmc_pkg::MAX_POINTS))
    else $error("point count above capacity");
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_AS_ACC) |-> ({1'b0, best_idx} < k_eff))
    else $error("assigned cluster beyond cluster count");
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("item taken while busy");
  a_div_only_update: assert property (@(posedge clk) disable iff (rst)
    div_done |-> $past(state == S_UP_WAIT))
    else $error("divider finished outside the update round");
`endif
endmodule
